### sv/gsd_pkg.sv
// Shared types and constants for the graphic segment deframer.
// Used by gsd_front, gsd_queue, gsd_back and the top level; no dependencies.
package gsd_pkg;

  localparam int unsigned HeaderBytes = 13;
  localparam int unsigned PosW        = 17;
  localparam int unsigned LenW        = 16;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned KindW       = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned OutDataW    = 112;
  localparam int unsigned OutUserW    = 4;

  localparam logic [7:0] MagicP    = 8'h50;
  localparam logic [7:0] MagicG    = 8'h47;
  localparam logic [7:0] TypePal   = 8'h14;
  localparam logic [7:0] TypeObj   = 8'h15;
  localparam logic [7:0] TypeComp  = 8'h16;
  localparam logic [7:0] TypeWin   = 8'h17;
  localparam logic [7:0] TypeEnd   = 8'h80;

  // header byte offsets
  localparam logic [PosW-1:0] PosMagicP   = 17'd0;
  localparam logic [PosW-1:0] PosMagicG   = 17'd1;
  localparam logic [PosW-1:0] PosPresLast = 17'd5;
  localparam logic [PosW-1:0] PosDecLast  = 17'd9;
  localparam logic [PosW-1:0] PosType     = 17'd10;
  localparam logic [PosW-1:0] PosHdrLast  = PosW'(HeaderBytes - 1);
  localparam logic [PosW-1:0] PosHdrEnd   = PosW'(HeaderBytes);

  typedef enum logic [KindW-1:0] {
    KIND_PALETTE = 3'd0,
    KIND_OBJECT  = 3'd1,
    KIND_COMP    = 3'd2,
    KIND_WINDOW  = 3'd3,
    KIND_END     = 3'd4,
    KIND_OTHER   = 3'd5
  } gsd_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TRUNC     = 2'd2
  } gsd_status_e;

  // what the back end does with its captured header fields
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PRES  = 3'd2,
    OP_DEC   = 3'd3,
    OP_KIND  = 3'd4
  } gsd_op_e;

  typedef struct packed {
    gsd_op_e          op;
    logic [7:0]       data;
    logic             last;
    logic             payload;
    logic             seg_end;
    gsd_status_e      status;
    logic [PosW-1:0]  offset;
    logic [LenW-1:0]  length;
  } gsd_item_t;

  function automatic gsd_kind_e kind_code(input logic [7:0] b);
    gsd_kind_e k;
    case (b)
      TypePal:  k = KIND_PALETTE;
      TypeObj:  k = KIND_OBJECT;
      TypeComp: k = KIND_COMP;
      TypeWin:  k = KIND_WINDOW;
      TypeEnd:  k = KIND_END;
      default:  k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

### sv/gsd_front.sv
// Front end: tracks the place in the segment, checks the magic, captures the
// length and classifies each byte into a queue item. Depends on gsd_pkg.
module gsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [7:0]         data_i,
  input  logic               last_i,
  input  logic               room_i,
  output logic               push_o,
  output gsd_pkg::gsd_item_t item_o
);

  logic [gsd_pkg::PosW-1:0] pos_q, pos_d;
  logic [gsd_pkg::LenW-1:0] len_q, len_d;
  logic                     err_q, err_d;
  logic                     fire;
  logic                     seg_end;
  logic [gsd_pkg::PosW-1:0] end_pos;

  assign fire    = valid_i & room_i;
  assign push_o  = fire;
  assign end_pos = {1'b0, len_q} + gsd_pkg::PosHdrLast;

  always_comb begin
    pos_d          = pos_q;
    len_d          = len_q;
    err_d          = err_q;
    seg_end        = 1'b0;
    item_o.op      = gsd_pkg::OP_NONE;
    item_o.data    = data_i;
    item_o.last    = last_i;
    item_o.payload = 1'b0;
    item_o.seg_end = 1'b0;
    item_o.status  = gsd_pkg::ST_OK;
    item_o.offset  = '0;
    if (err_q) begin
      // dropping until buffer end
      item_o.status = gsd_pkg::ST_BAD_MAGIC;
    end else begin
      item_o.offset = pos_q;
      if (pos_q < gsd_pkg::PosHdrEnd) begin
        if (pos_q == gsd_pkg::PosMagicP) begin
          item_o.op = gsd_pkg::OP_CLEAR;
          len_d     = '0;
          if (data_i != gsd_pkg::MagicP) err_d = 1'b1;
        end else if (pos_q == gsd_pkg::PosMagicG) begin
          if (data_i != gsd_pkg::MagicG) err_d = 1'b1;
        end else if (pos_q <= gsd_pkg::PosPresLast) begin
          item_o.op = gsd_pkg::OP_PRES;
        end else if (pos_q <= gsd_pkg::PosDecLast) begin
          item_o.op = gsd_pkg::OP_DEC;
        end else if (pos_q == gsd_pkg::PosType) begin
          item_o.op = gsd_pkg::OP_KIND;
        end else begin
          len_d = {len_q[7:0], data_i};
          if (pos_q == gsd_pkg::PosHdrLast && len_d == '0) seg_end = 1'b1;
        end
      end else begin
        item_o.payload = 1'b1;
        if (pos_q >= end_pos) seg_end = 1'b1;
      end
      if (err_d) begin
        item_o.status = gsd_pkg::ST_BAD_MAGIC;
      end else begin
        item_o.seg_end = seg_end;
        pos_d = seg_end ? '0 : pos_q + 1'b1;
        if (last_i && !seg_end) item_o.status = gsd_pkg::ST_TRUNC;
      end
    end
    item_o.length = len_d;
    if (last_i) begin
      pos_d = '0;
      err_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      err_q <= 1'b0;
    end else if (fire) begin
      pos_q <= pos_d;
      len_q <= len_d;
      err_q <= err_d;
    end
  end

endmodule

### sv/gsd_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on gsd_pkg for the item type.
module gsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gsd_pkg::gsd_item_t item_i,
  output logic               room_o,
  input  logic               pop_i,
  output logic               avail_o,
  output gsd_pkg::gsd_item_t item_o
);

  gsd_pkg::gsd_item_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  assign room_o  = (cnt_q != 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### sv/gsd_back.sv
// Back end: applies header captures (kind, times) and holds the result beat
// in an output register. Depends on gsd_pkg.
module gsd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         avail_i,
  input  gsd_pkg::gsd_item_t           item_i,
  output logic                         pop_o,
  output logic                         valid_o,
  input  logic                         ready_i,
  output gsd_pkg::gsd_item_t           res_o,
  output gsd_pkg::gsd_kind_e           kind_o,
  output logic [gsd_pkg::TimeW-1:0]    pres_o,
  output logic [gsd_pkg::TimeW-1:0]    dec_o
);

  gsd_pkg::gsd_kind_e            kind_q, kind_d;
  logic [gsd_pkg::TimeW-1:0]     pres_q, pres_d, dec_q, dec_d;
  logic                          valid_q;
  gsd_pkg::gsd_item_t            res_q;
  gsd_pkg::gsd_kind_e            okind_q;
  logic [gsd_pkg::TimeW-1:0]     opres_q, odec_q;

  assign pop_o = avail_i & (~valid_q | ready_i);

  always_comb begin
    kind_d = kind_q;
    pres_d = pres_q;
    dec_d  = dec_q;
    case (item_i.op)
      gsd_pkg::OP_CLEAR: begin
        kind_d = gsd_pkg::KIND_PALETTE;
        pres_d = '0;
        dec_d  = '0;
      end
      gsd_pkg::OP_PRES: pres_d = {pres_q[gsd_pkg::TimeW-9:0], item_i.data};
      gsd_pkg::OP_DEC:  dec_d  = {dec_q[gsd_pkg::TimeW-9:0], item_i.data};
      gsd_pkg::OP_KIND: kind_d = gsd_pkg::kind_code(item_i.data);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= gsd_pkg::KIND_PALETTE;
      pres_q  <= '0;
      dec_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        kind_q  <= kind_d;
        pres_q  <= pres_d;
        dec_q   <= dec_d;
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q   <= item_i;
      okind_q <= kind_d;
      opres_q <= pres_d;
      odec_q  <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign kind_o  = okind_q;
  assign pres_o  = opres_q;
  assign dec_o   = odec_q;

endmodule

### sv/graphic_segment_deframer.sv
// Top level of the presentation-graphic segment deframer.
// Instantiates gsd_front, gsd_queue and gsd_back; depends on gsd_pkg.
//
//   channel   dir  tdata                          tuser               tlast
//   s_axis    in   [7:0] byte                     -                   buffer end
//   m_axis    out  byte,pres,dec,len,ofs,end,st   is_payload,seg_kind buffer end
//
// One beat in and one beat out per cycle when both sides flow; each beat is
// registered in the queue and then in the output register.
// The front end's position/length update is the feedback loop that sets the rate.
// A two-beat queue plus the output register let the input keep flowing while
// m_axis_tready is low, until three beats are held.
// Reset clears position, error flag, captured header fields and all valids.
module graphic_segment_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte, [39:8] pres_time, [71:40] dec_time, [87:72] seg_length,
  // [104:88] byte_offset, [105] seg_end, [107:106] status, [111:108] zero
  output logic [gsd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [gsd_pkg::OutUserW-1:0] m_axis_tuser,  // [0] is_payload, [3:1] seg_kind
  output logic         m_axis_tlast
);

  logic                          push, room, pop, avail;
  gsd_pkg::gsd_item_t            f_item, q_item, res;
  gsd_pkg::gsd_kind_e            kind;
  logic [gsd_pkg::TimeW-1:0]     pres, dec;

  gsd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .room_i  (room),
    .push_o  (push),
    .item_o  (f_item)
  );

  gsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .room_o  (room),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (q_item)
  );

  gsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .item_i  (q_item),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .kind_o  (kind),
    .pres_o  (pres),
    .dec_o   (dec)
  );

  assign s_axis_tready = room;
  assign m_axis_tdata  = {4'b0000, res.status, res.seg_end, res.offset, res.length,
                          dec, pres, res.data};
  assign m_axis_tuser  = {kind, res.payload};
  assign m_axis_tlast  = res.last;

  // dropped bytes are never payload nor segment ends
  a_drop_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == gsd_pkg::ST_BAD_MAGIC |-> !res.payload && !res.seg_end)
    else $error("bad-magic beat tagged as payload or segment end");

  // a complete segment end is always ok
  a_end_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.seg_end |-> res.status == gsd_pkg::ST_OK)
    else $error("segment end with non-ok status");

  // truncation only on the buffer's last byte
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == gsd_pkg::ST_TRUNC |-> res.last)
    else $error("truncated status away from buffer end");

  // payload bytes lie beyond the header
  a_payload_ofs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.payload |-> res.offset >= gsd_pkg::PosHdrEnd)
    else $error("payload beat inside header");

endmodule
